// ----- rtl/core/gdn_pkg.sv -----
package gdn_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthInW = 7;
  localparam int unsigned DayInW  = 7;
  localparam int unsigned NumW    = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned YLenW   = 9;

  // Calendar constants
  localparam logic [MonthW-1:0] MonthJan    = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb    = 4'd2;
  localparam logic [MonthW-1:0] MonthDec    = 4'd12;
  localparam logic [DayW-1:0]   LeapFebDays = 5'd29;
  localparam logic [YLenW-1:0]  YearDays    = 9'd365;
  localparam logic [YLenW-1:0]  LeapYearDays = 9'd366;

  localparam logic [DayW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Request conversion kinds
  localparam logic KindToNumber = 1'b0;
  localparam logic KindToDate   = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [YearW-1:0]    year_in;
    logic [MonthInW-1:0] month_in;
    logic [DayInW-1:0]   day_in;
    logic [NumW-1:0]     number_in;
  } req_t;

  typedef struct packed {
    logic              valid_res;
    logic [NumW-1:0]   number_out;
    logic [YearW-1:0]  year_out;
    logic [MonthW-1:0] month_out;
    logic [DayW-1:0]   day_out;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic year_adv;
    logic month_adv;
    logic finish;
    logic fail;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pre_ok;
    logic year_over;
    logic year_end;
    logic month_end;
  } sts_t;

  // Length of a month, zero for a code that is no month
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    len = '0;
    if (month >= MonthJan && month <= MonthDec) begin
      len = MonthLen[month - MonthJan];
      if (month == MonthFeb && leap) begin
        len = LeapFebDays;
      end
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/gdn_datapath.sv -----
module gdn_datapath #(
  parameter int EPOCH_YEAR = 2000,
  parameter int LAST_YEAR  = 2030
) (
  input  logic            clk_i,
  input  gdn_pkg::req_t   req_i,
  input  gdn_pkg::cmd_t   cmd_i,
  output gdn_pkg::sts_t   sts_o,
  output gdn_pkg::res_t   res_o
);

  localparam logic [gdn_pkg::YearW-1:0] EpochY = gdn_pkg::YearW'(EPOCH_YEAR);
  localparam logic [gdn_pkg::YearW-1:0] LastY  = gdn_pkg::YearW'(LAST_YEAR);
  localparam logic [1:0] EpochMod4   = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0] EpochMod100 = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0] EpochMod400 = 9'(EPOCH_YEAR % 400);

  // Latched request
  logic                         kind_q;
  logic [gdn_pkg::YearW-1:0]    year_q;
  logic [gdn_pkg::MonthInW-1:0] month_q;
  logic [gdn_pkg::DayInW-1:0]   day_q;

  // Walk state: current year, its residues, current month, running count
  logic [gdn_pkg::YearW-1:0]  y_q, y_d;
  logic [1:0]                 mod4_q, mod4_d;
  logic [6:0]                 mod100_q, mod100_d;
  logic [8:0]                 mod400_q, mod400_d;
  logic [gdn_pkg::MonthW-1:0] m_q, m_d;
  logic [gdn_pkg::NumW-1:0]   cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  gdn_pkg::res_t              res_q, res_d;

  logic                        leap;
  logic [gdn_pkg::YLenW-1:0]   ylen;
  logic [gdn_pkg::DayW-1:0]    mlen;
  logic [gdn_pkg::NumW:0]      step_len;
  logic [gdn_pkg::NumW:0]      sum;
  logic [gdn_pkg::NumW:0]      day_sum;
  logic                        day_ok;

  // Leap rule on the current year from its residues
  assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign ylen = leap ? gdn_pkg::LeapYearDays : gdn_pkg::YearDays;
  assign mlen = gdn_pkg::month_days(m_q, leap);

  // Status toward the controller
  always_comb begin
    sts_o.pre_ok = 1'b1;
    if (kind_q == gdn_pkg::KindToNumber) begin
      sts_o.pre_ok = (month_q >= gdn_pkg::MonthInW'(gdn_pkg::MonthJan)) &&
                     (month_q <= gdn_pkg::MonthInW'(gdn_pkg::MonthDec)) &&
                     (year_q >= EpochY) && (year_q <= LastY);
    end
    sts_o.year_over = (kind_q == gdn_pkg::KindToDate) && (y_q > LastY);
    if (kind_q == gdn_pkg::KindToDate) begin
      sts_o.year_end  = cnt_q < gdn_pkg::NumW'(ylen);
      sts_o.month_end = cnt_q < gdn_pkg::NumW'(mlen);
    end else begin
      sts_o.year_end  = y_q == year_q;
      sts_o.month_end = m_q == month_q[gdn_pkg::MonthW-1:0];
    end
  end

  // One add or subtract per step: year length or month length
  assign step_len = cmd_i.year_adv ? (gdn_pkg::NumW+1)'(ylen) : (gdn_pkg::NumW+1)'(mlen);
  assign sum = (kind_q == gdn_pkg::KindToDate) ? {1'b0, cnt_q} - step_len
                                               : {1'b0, cnt_q} + step_len;
  assign day_sum = {1'b0, cnt_q} + (gdn_pkg::NumW+1)'(day_q) - (gdn_pkg::NumW+1)'(1);
  assign day_ok  = (day_q != '0) && (day_q <= gdn_pkg::DayInW'(mlen));

  // Next walk state
  always_comb begin
    y_d      = y_q;
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    m_d      = m_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    res_d    = res_q;
    if (cmd_i.load) begin
      y_d      = EpochY;
      mod4_d   = EpochMod4;
      mod100_d = EpochMod100;
      mod400_d = EpochMod400;
      m_d      = gdn_pkg::MonthJan;
      cnt_d    = (req_i.kind == gdn_pkg::KindToDate) ? req_i.number_in : '0;
      ovf_d    = 1'b0;
    end
    if (cmd_i.year_adv) begin
      y_d      = y_q + gdn_pkg::YearW'(1);
      mod4_d   = mod4_q + 2'd1;
      mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end
    if (cmd_i.month_adv) begin
      m_d = m_q + gdn_pkg::MonthW'(1);
    end
    if (cmd_i.year_adv || cmd_i.month_adv) begin
      cnt_d = sum[gdn_pkg::NumW-1:0];
      ovf_d = ovf_q | ((kind_q == gdn_pkg::KindToNumber) && sum[gdn_pkg::NumW]);
    end
    // Build the result beat
    if (cmd_i.fail) begin
      res_d = '0;
    end
    if (cmd_i.finish) begin
      res_d = '0;
      if (kind_q == gdn_pkg::KindToDate) begin
        res_d.valid_res = 1'b1;
        res_d.year_out  = y_q;
        res_d.month_out = m_q;
        res_d.day_out   = cnt_q[gdn_pkg::DayW-1:0] + gdn_pkg::DayW'(1);
      end else if (day_ok && !ovf_q && !day_sum[gdn_pkg::NumW]) begin
        res_d.valid_res  = 1'b1;
        res_d.number_out = day_sum[gdn_pkg::NumW-1:0];
      end
    end
  end

  // Hold request and walk state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_i.kind;
      year_q  <= req_i.year_in;
      month_q <= req_i.month_in;
      day_q   <= req_i.day_in;
    end
    y_q      <= y_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    m_q      <= m_d;
    cnt_q    <= cnt_d;
    ovf_q    <= ovf_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/gdn_ctrl.sv -----
module gdn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  gdn_pkg::sts_t sts_i,
  output gdn_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StYear,
    StMonth
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  // Decode commands from state and status
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.pre_ok) begin
          state_d = StYear;
        end else begin
          cmd_o.fail = 1'b1;
          state_d    = StIdle;
        end
      end
      StYear: begin
        if (sts_i.year_over) begin
          cmd_o.fail = 1'b1;
          state_d    = StIdle;
        end else if (sts_i.year_end) begin
          state_d = StMonth;
        end else begin
          cmd_o.year_adv = 1'b1;
        end
      end
      StMonth: begin
        if (sts_i.month_end) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.month_adv = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, busy and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish | cmd_o.fail;
      if (cmd_o.load) begin
        busy_q <= 1'b1;
      end else if (cmd_o.finish || cmd_o.fail) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/gregorian_date_day_number_core.sv -----
// Gregorian date to day number converter, and back.
// Request channel: drive req_i and pulse start while busy is low; the beat
// is taken at that clock edge. kind 0 turns year/month/day into the count of
// days since 1 January of EPOCH_YEAR; kind 1 turns such a count into a date.
// Result channel: res_o carries one beat per request, marked by done_o for
// exactly one cycle; res_o.valid_res is low for a date or count outside the
// EPOCH_YEAR..LAST_YEAR window, with all other fields zero.
// The controller walks one year per cycle, then one month per
// cycle; a request rejected up front skips the walk. busy stays high
// until the result beat is shown, and a new request may be started in
// the cycle that shows it.
// The receiver has no stall: done_o must be sampled when it is high.
// Reset (rst_ni low, asynchronous) returns the controller to idle with busy
// and done_o low; any request in flight is dropped.
module gregorian_date_day_number_core #(
  parameter int EPOCH_YEAR = 2000,
  parameter int LAST_YEAR  = 2030
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gdn_pkg::req_t req_i,
  output logic          done_o,
  output gdn_pkg::res_t res_o
);

  gdn_pkg::cmd_t cmd;
  gdn_pkg::sts_t sts;

  // Sequence the walk
  gdn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start & ~busy),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Year and month arithmetic
  gdn_datapath #(
    .EPOCH_YEAR (EPOCH_YEAR),
    .LAST_YEAR  (LAST_YEAR)
  ) u_datapath (
    .clk_i (clk_i),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule

// ----- rtl/core/gdn_checker.sv -----
module gdn_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_i,
  input gdn_pkg::res_t res_i
);

  // Accepted beat keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  // Result strobe lasts one cycle and comes with busy released
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_i |-> !busy)
    else $error("result shown while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_i |=> !done_i)
    else $error("result strobe longer than one cycle");

  // Busy drops only together with a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_i)
    else $error("busy dropped without result");

  // Invalid result carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && !res_i.valid_res |->
      res_i.number_out == '0 && res_i.year_out == '0 &&
      res_i.month_out == '0 && res_i.day_out == '0)
    else $error("invalid result with nonzero fields");

endmodule

bind gregorian_date_day_number_core gdn_checker u_gdn_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o),
  .res_i  (res_o)
);
